### hdl/phr_pkg.sv
// Shared types and constants for the pixel hue replacement pipeline.
// No dependencies; every module imports it.
package phr_pkg;

  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned HUE_W       = 13;
  localparam int unsigned P_W         = 19;   // signed p
  localparam int unsigned Q_W         = 18;   // q and q - p

  localparam logic [12:0] HUE_FULL       = 13'd5760;
  localparam logic [12:0] HUE_THIRD      = 13'd1920;
  localparam logic [12:0] HUE_SIXTH      = 13'd960;
  localparam logic [12:0] HUE_HALF       = 13'd2880;
  localparam logic [12:0] HUE_TWO_THIRDS = 13'd3840;

  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_BITS   = 4;

  localparam int unsigned CH_STAGES  = 5;
  localparam int unsigned LANES      = 3;

  // floor(2^24 / 15): reciprocal for the divide by 960 (= 64 * 15)
  localparam logic [20:0] RECIP15    = 21'd1118481;

  typedef enum logic [1:0] {
    CM_RAMP,
    CM_HIGH,
    CM_LOW
  } chan_mode_t;

endpackage

### hdl/phr_hsl.sv
// Lightness and saturation: min/max stage then a pipelined restoring divider.
// Depends on phr_pkg.
module phr_hsl import phr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FRAC_W-1:0] l_out,
  output logic [FRAC_W-1:0] s_out,
  output logic              lt_out
);

  logic              vld   [0:DIV_STAGES];
  logic              en    [0:DIV_STAGES];
  logic [7:0]        rem   [0:DIV_STAGES];
  logic [15:0]       low   [0:DIV_STAGES];
  logic [15:0]       quo   [0:DIV_STAGES];
  logic [7:0]        den   [0:DIV_STAGES];
  logic [FRAC_W-1:0] lval  [0:DIV_STAGES];
  logic              lt    [0:DIV_STAGES];
  logic              grey  [0:DIV_STAGES];

  logic [7:0]  mx, mn, d, den_next;
  logic [8:0]  sum;
  logic [16:0] l_wide;

  always_comb begin
    en[DIV_STAGES] = !vld[DIV_STAGES] || out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    sum    = {1'b0, mx} + {1'b0, mn};
    d      = mx - mn;
    l_wide = 17'(sum * 9'd257);
    den_next = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
    if (en[0]) begin
      // d * 65535 = (d - 1) * 2^16 + (2^16 - d) for d > 0
      rem[0]  <= d - 8'd1;
      low[0]  <= 16'd0 - {8'd0, d};
      quo[0]  <= '0;
      den[0]  <= den_next;
      lval[0] <= l_wide[16:1];
      lt[0]   <= sum < 9'd255;
      grey[0] <= d == 8'd0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [7:0]  rem_next;
    logic [15:0] low_next, quo_next;

    always_comb begin : step
      logic [8:0] r9;
      r9       = '0;
      rem_next = rem[k-1];
      low_next = low[k-1];
      quo_next = quo[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        r9       = {rem_next, low_next[15]};
        low_next = {low_next[14:0], 1'b0};
        if (r9 >= {1'b0, den[k-1]}) begin
          r9       = r9 - {1'b0, den[k-1]};
          quo_next = {quo_next[14:0], 1'b1};
        end else begin
          quo_next = {quo_next[14:0], 1'b0};
        end
        rem_next = r9[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
      if (en[k]) begin
        rem[k]  <= rem_next;
        low[k]  <= low_next;
        quo[k]  <= quo_next;
        den[k]  <= den[k-1];
        lval[k] <= lval[k-1];
        lt[k]   <= lt[k-1];
        grey[k] <= grey[k-1];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign l_out     = lval[DIV_STAGES];
  assign lt_out    = lt[DIV_STAGES];
  // grey pixels carry zero saturation, so q = p = l downstream
  assign s_out     = grey[DIV_STAGES] ? '0 : quo[DIV_STAGES];

endmodule

### hdl/phr_mix.sv
// p/q stage: l*s product, exact divide by 65535, then q, p and q - p.
// Depends on phr_pkg.
module phr_mix import phr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FRAC_W-1:0]     l_in,
  input  logic [FRAC_W-1:0]     s_in,
  input  logic                  lt_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [P_W-1:0] p_out,
  output logic [Q_W-1:0]        q_out,
  output logic [Q_W-1:0]        diff_out
);

  logic              v1, v2, en1, en2;
  logic [31:0]       prod;
  logic [FRAC_W-1:0] l1, s1;
  logic              lt1;

  logic [15:0]       q0, ls;
  logic [16:0]       r0, qml;
  logic [Q_W-1:0]    q_next;
  logic signed [P_W-1:0] p_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      prod <= l_in * s_in;
      l1   <= l_in;
      s1   <= s_in;
      lt1  <= lt_in;
    end
  end

  always_comb begin
    q0  = prod[31:16];
    r0  = {1'b0, prod[15:0]} + {1'b0, q0};
    ls  = (r0 >= 17'd65535) ? q0 + 16'd1 : q0;
    q_next = lt1 ? {2'b00, l1} + {2'b00, ls}
                 : {2'b00, l1} + {2'b00, s1} - {2'b00, ls};
    p_next = $signed({2'b00, l1, 1'b0}) - $signed({1'b0, q_next});
    qml    = 17'(q_next - {2'b00, l1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      q_out    <= q_next;
      p_out    <= p_next;
      diff_out <= {qml, 1'b0};
    end
  end

  assign out_valid = v2;

endmodule

### hdl/phr_chan.sv
// Hue-to-channel lanes for red, green and blue, with clamp and divide by 257.
// Depends on phr_pkg.
module phr_chan import phr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [HUE_W-1:0]      hue,
  input  logic signed [P_W-1:0] p_in,
  input  logic [Q_W-1:0]        q_in,
  input  logic [Q_W-1:0]        diff_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            chan_out [0:LANES-1]
);

  logic vld [0:CH_STAGES-1];
  logic en  [0:CH_STAGES-1];

  always_comb begin
    en[CH_STAGES-1] = !vld[CH_STAGES-1] || out_ready;
    for (int k = CH_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[CH_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CH_STAGES; k++) vld[k] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < CH_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // hue positions per lane
  logic [HUE_W-1:0] h;
  logic [HUE_W-1:0] t [0:LANES-1];
  logic [HUE_W-1:0] tr_raw;

  always_comb begin
    h      = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
    tr_raw = h + HUE_THIRD;
    t[0]   = (tr_raw >= HUE_FULL) ? tr_raw - HUE_FULL : tr_raw;
    t[1]   = h;
    t[2]   = (h < HUE_THIRD) ? h + (HUE_FULL - HUE_THIRD) : h - HUE_THIRD;
  end

  // shared p and q travel alongside
  logic signed [P_W-1:0] p1, p2;
  logic [Q_W-1:0]        q1, q2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= p_in;
      q1 <= q_in;
    end
    if (en[1]) begin
      p2 <= p1;
      q2 <= q1;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    chan_mode_t  mode_next, mode1, mode2;
    logic [9:0]  f;
    logic [27:0] prod1;
    logic [21:0] y2;
    logic [42:0] m2;
    logic [18:0] qe;
    logic [21:0] rr;
    logic signed [P_W:0] v_raw;
    logic [15:0] v3, v4;
    logic [23:0] w4;
    logic [7:0]  qe2;
    logic [16:0] r2;

    always_comb begin
      f = '0;
      if (t[i] < HUE_SIXTH) begin
        mode_next = CM_RAMP;
        f         = t[i][9:0];
      end else if (t[i] < HUE_HALF) begin
        mode_next = CM_HIGH;
      end else if (t[i] < HUE_TWO_THIRDS) begin
        mode_next = CM_RAMP;
        f         = 10'(HUE_TWO_THIRDS - t[i]);
      end else begin
        mode_next = CM_LOW;
      end
    end

    always_comb begin
      qe = m2[42:24];
      rr = y2 - {3'd0, qe} * 22'd15;
      if (rr >= 22'd15) qe = qe + 19'd1;
      case (mode2)
        CM_RAMP: v_raw = {p2[P_W-1], p2} + $signed({1'b0, qe});
        CM_HIGH: v_raw = $signed({2'b00, q2});
        CM_LOW:  v_raw = {p2[P_W-1], p2};
        default: v_raw = {p2[P_W-1], p2};
      endcase
    end

    always_comb begin
      qe2 = w4[23:16];
      r2  = {1'b0, v4} - {9'd0, qe2} * 17'd257;
      if (r2 >= 17'd257) qe2 = qe2 + 8'd1;
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        prod1 <= diff_in * f;
        mode1 <= mode_next;
      end
      if (en[1]) begin
        y2    <= prod1[27:6];
        m2    <= prod1[27:6] * RECIP15;
        mode2 <= mode1;
      end
      if (en[2]) begin
        // clamp to 0..65535
        if (v_raw < 0) begin
          v3 <= '0;
        end else if (v_raw > $signed({4'd0, 16'hFFFF})) begin
          v3 <= 16'hFFFF;
        end else begin
          v3 <= v_raw[15:0];
        end
      end
      if (en[3]) begin
        v4 <= v3;
        w4 <= v3 * 8'd255;
      end
      if (en[4]) chan_out[i] <= qe2;
    end
  end

endmodule

### hdl/pixel_hue_replace.sv
// Pixel hue replacement: RGB -> HSL -> RGB with a configured hue.
// Top level; depends on phr_pkg, phr_hsl, phr_mix and phr_chan.
//
// Usage:
//   s_axis carries one RGB pixel per transaction, m_axis returns the pixel
//   with its hue replaced by target_hue (sixteenths of a degree, 0..5760;
//   values above 5760 wrap). Saturation and lightness of the source pixel
//   are kept; grey pixels stay grey.
//   Write target_hue through cfg_wen/cfg_wdata while the pipeline is empty.
// Pipeline: 12 register stages (1 min/max stage, 4 divider stages of 4
//   quotient bits each, 2 p/q stages, 5 channel stages, output register
//   included).
// Throughput: one pixel per clock while m_axis_tready is high; the 16-bit
//   saturation divide is spread over the four divider stages so every stage can take a new pixel each cycle.
// Reset (rst, synchronous): empties all stages and sets target_hue to 0.
// Stall: when m_axis_tready is low the output holds and each stage holds
//   only once the stage after it is full, so bubbles are squeezed out and
//   s_axis_tready drops only when the whole pipeline is full.
module pixel_hue_replace import phr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata,       // target_hue
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // red_out[7:0], green_out[15:8], blue_out[23:16]
);

  logic [HUE_W-1:0] target_hue;

  // hold the configured hue; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      target_hue <= '0;
    end else if (cfg_wen) begin
      target_hue <= cfg_wdata;
    end
  end

  logic              hsl_valid, hsl_ready;
  logic [FRAC_W-1:0] l, s;
  logic              lt;

  phr_hsl u_hsl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red       (s_axis_tdata[7:0]),
    .green     (s_axis_tdata[15:8]),
    .blue      (s_axis_tdata[23:16]),
    .out_valid (hsl_valid),
    .out_ready (hsl_ready),
    .l_out     (l),
    .s_out     (s),
    .lt_out    (lt)
  );

  logic                  mix_valid, mix_ready;
  logic signed [P_W-1:0] p;
  logic [Q_W-1:0]        q, diff;

  phr_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsl_valid),
    .in_ready  (hsl_ready),
    .l_in      (l),
    .s_in      (s),
    .lt_in     (lt),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .p_out     (p),
    .q_out     (q),
    .diff_out  (diff)
  );

  logic [7:0] chan [0:LANES-1];

  phr_chan u_chan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .hue       (target_hue),
    .p_in      (p),
    .q_in      (q),
    .diff_in   (diff),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .chan_out  (chan)
  );

  assign m_axis_tdata = {chan[2], chan[1], chan[0]};

  // an empty output stage must let every stage advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a receiver that takes every result never stalls the input
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented right after reset");

endmodule

### tb/sv/tb_pixel_hue_replace.sv
// Self-checking testbench for pixel_hue_replace: directed table then random pixels,
// compared against an integer HSL hue-replacement predictor. Depends on phr_pkg.
module tb_pixel_hue_replace;
  import phr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct {
    pixel_t     pix;
    logic       has_exp;  // expected result typed in
    pixel_t     exp;
  } row_t;

  localparam int LATENCY = 14;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  logic [12:0] hue_now;       // predictor copy of target_hue
  pixel_t      recoloured_q[$];
  int          errors = 0;
  bit          calm = 1'b0;   // no idling in the last part of the run

  pixel_hue_replace u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_pixel_hue_replace NOT OK");
    $finish;
  end

  // Hue position to channel level, 16-bit fraction, then down to 8 bits.
  function automatic logic [7:0] hue_to_level(longint p, longint q, longint t);
    longint v;
    if (t < 960) v = p + ((q - p) * t) / 960;
    else if (t < 2880) v = q;
    else if (t < 3840) v = p + ((q - p) * (3840 - t)) / 960;
    else v = p;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 8'(v / 257);
  endfunction

  function automatic pixel_t recolour(pixel_t px, logic [12:0] hue);
    longint mx, mn, sum, d, l, s, q, p, h, tr, tb;
    pixel_t o;
    mx = px.red; mn = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn) mn = px.blue;
    sum = mx + mn;
    d = mx - mn;
    l = (sum * 257) / 2;
    if (d == 0) begin
      o.red = 8'(l / 257); o.green = o.red; o.blue = o.red;
      return o;
    end
    s = (sum <= 255) ? (d * 65535) / sum : (d * 65535) / (510 - sum);
    q = (sum < 255) ? l + (l * s) / 65535 : l + s - (l * s) / 65535;
    p = 2 * l - q;
    h = hue;
    if (h >= 5760) h -= 5760;
    tr = h + 1920; if (tr >= 5760) tr -= 5760;
    tb = h - 1920; if (tb < 0) tb += 5760;
    o.red = hue_to_level(p, q, tr);
    o.green = hue_to_level(p, q, h);
    o.blue = hue_to_level(p, q, tb);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // Sink: random stalls, compare every completed transaction with the oldest expectation.
  initial begin
    int stall;
    pixel_t got, want;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 8);
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (recoloured_q.size() == 0) begin
          errors++;
          $display("%0t unexpected pixel %h", $realtime, got);
        end else begin
          want = recoloured_q.pop_front();
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        end
      end
      @(negedge clk);
    end
  end

  // Send one pixel, holding tvalid until the transaction completes.
  task automatic send_pixel(pixel_t px);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
    recoloured_q.push_back(recolour(px, hue_now));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (recoloured_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_hue(logic [12:0] hue);
    cfg_wen <= 1'b1;
    cfg_wdata <= hue;
    @(negedge clk);
    cfg_wen <= 1'b0;
    hue_now = hue;
  endtask

  function automatic row_t mk(int r, int g, int b, bit known = 0, int er = 0, int eg = 0,
                              int eb = 0);
    row_t x;
    x.pix = '{blue: 8'(b), green: 8'(g), red: 8'(r)};
    x.has_exp = known;
    x.exp = '{blue: 8'(eb), green: 8'(eg), red: 8'(er)};
    return x;
  endfunction

  initial begin
    row_t dir[$];
    logic [12:0] hues[$] = '{13'd0, 13'd5760, 13'd8191, 13'd959, 13'd960, 13'd2879,
                             13'd3840, 13'd1920, 13'd5759, 13'd5761};
    pixel_t px;
    int n;
    hue_now = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: greys (black, white, mid) are hue-independent; extremes and
    // both lightness halves, including the sum == 255 split.
    dir.push_back(mk(0, 0, 0, 1, 0, 0, 0));
    dir.push_back(mk(255, 255, 255, 1, 255, 255, 255));
    dir.push_back(mk(128, 128, 128, 1, 128, 128, 128));
    dir.push_back(mk(255, 0, 0));
    dir.push_back(mk(0, 255, 0));
    dir.push_back(mk(0, 0, 255));
    dir.push_back(mk(255, 255, 0));
    dir.push_back(mk(0, 255, 255));
    dir.push_back(mk(200, 55, 100));
    dir.push_back(mk(127, 128, 0));
    dir.push_back(mk(1, 0, 0));
    dir.push_back(mk(255, 254, 254));
    dir.push_back(mk(170, 85, 85));
    dir.push_back(mk(10, 200, 90));
    dir.push_back(mk(254, 1, 128));
    foreach (dir[i]) begin
      send_pixel(dir[i].pix);
      // overwrite the prediction where the value is plain from the row
      if (dir[i].has_exp) recoloured_q[recoloured_q.size() - 1] = dir[i].exp;
    end
    drain();

    // Random: sweep several hue settings, then random hues, last stretch calm.
    for (int phase = 0; phase < 20; phase++) begin
      write_hue(phase < hues.size() ? hues[phase] : 13'($urandom_range(0, 8191)));
      n = 70;
      if (phase >= 17) calm = 1'b1;
      repeat (n) begin
        px = 24'($urandom);
        if ($urandom_range(0, 9) == 0) px.green = px.red;
        if ($urandom_range(0, 19) == 0) begin px.green = px.red; px.blue = px.red; end
        send_pixel(px);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_pixel_hue_replace OK");
    end else begin
      $display("tb_pixel_hue_replace NOT OK");
    end
    $finish;
  end

endmodule
